// ----- sv/aac_pkg.sv -----
package aac_pkg;

   localparam int SAMPLE_BITS   = 10;
   localparam int RANGE_BITS    = 3;
   localparam int COUNT_BITS    = 8;
   localparam int HOLD_BITS     = 8;
   localparam int SQ_BITS       = 32;
   localparam int LVL_BITS      = 24;
   localparam int DIFF_BITS     = SAMPLE_BITS + 1;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 10;
   localparam int REQ_DATA_BITS = 16;
   localparam int REQ_USER_BITS = 3;
   localparam int RSP_DATA_BITS = 88;

   localparam logic [SAMPLE_BITS-1:0] SAT_HIGH_RESET = SAMPLE_BITS'(1000);
   localparam logic [SAMPLE_BITS-1:0] SAT_LOW_RESET  = SAMPLE_BITS'(23);
   localparam logic [HOLD_BITS-1:0]   HOLD_RESET     = HOLD_BITS'(4);
   localparam logic [SAMPLE_BITS-1:0] VGROUND_RESET  = SAMPLE_BITS'(512);
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX      = '1;
   localparam logic [SQ_BITS-1:0]     SQ_MAX         = '1;
   localparam logic [LVL_BITS-1:0]    LVL_MAX        = '1;
   localparam logic [SAMPLE_BITS-1:0] PEAK_LOW_RESET = '1;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_SET    = 2'd2
   } command_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_SAT_HIGH   = 3'd0,
      CSR_SAT_LOW    = 3'd1,
      CSR_HOLD       = 3'd2,
      CSR_RMS_MODE   = 3'd3,
      CSR_VGROUND_HV = 3'd4,
      CSR_VGROUND_FB = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sat_high;
      logic [SAMPLE_BITS-1:0] sat_low;
      logic [HOLD_BITS-1:0]   hold_reload;
      logic                   rms_mode;
      logic [SAMPLE_BITS-1:0] vground;
   } chan_cfg_type;

   typedef struct packed {
      logic                   sample_en;
      logic                   clear_en;
      logic                   set_en;
      logic [SAMPLE_BITS-1:0] sample;
      logic [RANGE_BITS-1:0]  set_index;
   } chan_op_type;

   typedef struct packed {
      logic [RANGE_BITS-1:0]  range_idx;
      logic [COUNT_BITS-1:0]  sat_count;
      logic [HOLD_BITS-1:0]   holdoff;
      logic [SQ_BITS-1:0]     sq_sum;
      logic [LVL_BITS-1:0]    lvl_sum;
      logic [SAMPLE_BITS-1:0] peak_high;
      logic [SAMPLE_BITS-1:0] peak_low;
   } chan_state_type;

endpackage

// ----- sv/aac_chan.sv -----
module aac_chan
   import aac_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  chan_op_type    op,
   input  chan_cfg_type   cfg,
   output chan_state_type state_in,
   output chan_state_type state_ff,
   output logic           limit_hit
);

   logic                        out_of_range;
   logic signed [DIFF_BITS-1:0] diff;
   logic signed [PROD_BITS-1:0] prod;
   logic [SQ_BITS:0]            sq_total;
   logic [LVL_BITS:0]           lvl_total;

   assign out_of_range = (op.sample > cfg.sat_high) || (op.sample < cfg.sat_low);
   assign diff = $signed({1'b0, op.sample}) - $signed({1'b0, cfg.vground});
   assign prod = diff * diff;
   assign sq_total = {1'b0, state_ff.sq_sum} + (SQ_BITS + 1)'(unsigned'(prod));
   assign lvl_total = {1'b0, state_ff.lvl_sum} + (LVL_BITS + 1)'(op.sample);

   always_comb begin
      state_in  = state_ff;
      limit_hit = 1'b0;
      if (op.clear_en) begin
         state_in.sat_count = '0;
         state_in.holdoff   = '0;
         state_in.sq_sum    = '0;
         state_in.lvl_sum   = '0;
         state_in.peak_high = '0;
         state_in.peak_low  = PEAK_LOW_RESET;
      end else if (op.set_en) begin
         state_in.range_idx = op.set_index;
      end else if (op.sample_en) begin
         if (out_of_range) begin
            if (state_ff.holdoff == '0) begin
               if (state_ff.sat_count != COUNT_MAX) begin
                  state_in.sat_count = state_ff.sat_count + COUNT_BITS'(1);
               end
               if (state_ff.range_idx != '0) begin
                  state_in.range_idx = state_ff.range_idx - RANGE_BITS'(1);
               end else begin
                  limit_hit = 1'b1;
               end
               state_in.holdoff = cfg.hold_reload;
            end else begin
               state_in.holdoff = state_ff.holdoff - HOLD_BITS'(1);
            end
         end else if (cfg.rms_mode) begin
            state_in.sq_sum  = sq_total[SQ_BITS] ? SQ_MAX : sq_total[SQ_BITS-1:0];
            state_in.lvl_sum = lvl_total[LVL_BITS] ? LVL_MAX : lvl_total[LVL_BITS-1:0];
         end else begin
            if (op.sample > state_ff.peak_high) begin
               state_in.peak_high = op.sample;
            end
            if (op.sample < state_ff.peak_low) begin
               state_in.peak_low = op.sample;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.range_idx <= '0;
         state_ff.sat_count <= '0;
         state_ff.holdoff   <= '0;
         state_ff.sq_sum    <= '0;
         state_ff.lvl_sum   <= '0;
         state_ff.peak_high <= '0;
         state_ff.peak_low  <= PEAK_LOW_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/autoranging_adc_accumulator.sv -----
// Channel  Direction  Handshake               Word
// req      in         req_tvalid/req_tready   command, channel, sample, resistor index
// rsp      out        rsp_tvalid/rsp_tready   status and window state of that channel
// csr      in         csr_wen                 register write, no read-back
//
// An accepted word lands in an input register, then one pass through the channel
// update fills the result register. One word is accepted per cycle while the result
// register is empty or being taken; the squaring multiply and the 32-bit saturating
// add lie between the two registers. Synchronous active-high reset restores the register
// defaults and clears both windows. A stalled result holds the pipeline; the input
// register still takes one word.
module autoranging_adc_accumulator
   import aac_pkg::*;
#(
   parameter int HV_TOP_INDEX = 2,
   parameter int FB_TOP_INDEX = 4
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // sample [9:0], resistor_setting [12:10], zero [15:13]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // command [1:0], channel [2]
   input  logic [REQ_USER_BITS-1:0] req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // range_index [2:0], saturation_count [10:3], limit_exceeded [11],
   // square_sum [43:12], level_sum [67:44], peak_high [77:68], peak_low [87:78]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // status [0]
   output logic                     rsp_tuser,
   input  logic                     csr_wen,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam logic [RANGE_BITS-1:0] HvTop = RANGE_BITS'(HV_TOP_INDEX);
   localparam logic [RANGE_BITS-1:0] FbTop = RANGE_BITS'(FB_TOP_INDEX);

   logic [SAMPLE_BITS-1:0] sat_high_ff;
   logic [SAMPLE_BITS-1:0] sat_low_ff;
   logic [HOLD_BITS-1:0]   hold_reload_ff;
   logic                   rms_mode_ff;
   logic [SAMPLE_BITS-1:0] vground_hv_ff;
   logic [SAMPLE_BITS-1:0] vground_fb_ff;

   logic                   in_valid_ff;
   logic [1:0]             in_cmd_ff;
   logic                   in_chan_ff;
   logic [SAMPLE_BITS-1:0] in_sample_ff;
   logic [RANGE_BITS-1:0]  in_index_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_status_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic                     rsp_status_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_in;

   logic                   limit_flag_ff;
   logic                   limit_flag_in;
   logic                   advance;
   logic                   fire;
   logic                   set_ok;
   logic                   is_sample;
   logic                   is_clear;
   logic                   is_set;
   logic                   is_bad;
   chan_op_type            op_hv;
   chan_op_type            op_fb;
   chan_cfg_type           cfg_hv;
   chan_cfg_type           cfg_fb;
   chan_state_type         hv_in;
   chan_state_type         hv_ff;
   chan_state_type         fb_in;
   chan_state_type         fb_ff;
   chan_state_type         sel_in;
   logic                   hit_hv;
   logic                   hit_fb;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_high_ff    <= SAT_HIGH_RESET;
         sat_low_ff     <= SAT_LOW_RESET;
         hold_reload_ff <= HOLD_RESET;
         rms_mode_ff    <= 1'b0;
         vground_hv_ff  <= VGROUND_RESET;
         vground_fb_ff  <= VGROUND_RESET;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_addr))
            CSR_SAT_HIGH:   sat_high_ff    <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_SAT_LOW:    sat_low_ff     <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_HOLD:       hold_reload_ff <= csr_wdata[HOLD_BITS-1:0];
            CSR_RMS_MODE:   rms_mode_ff    <= csr_wdata[0];
            CSR_VGROUND_HV: vground_hv_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_VGROUND_FB: vground_fb_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff    <= req_tuser[1:0];
         in_chan_ff   <= req_tuser[2];
         in_sample_ff <= req_tdata[SAMPLE_BITS-1:0];
         in_index_ff  <= req_tdata[SAMPLE_BITS+RANGE_BITS-1:SAMPLE_BITS];
      end
   end

   always_comb begin
      is_sample = 1'b0;
      is_clear  = 1'b0;
      is_set    = 1'b0;
      is_bad    = 1'b0;
      unique case (command_type'(in_cmd_ff))
         CMD_SAMPLE: is_sample = 1'b1;
         CMD_CLEAR:  is_clear  = 1'b1;
         CMD_SET:    is_set    = 1'b1;
         default:    is_bad    = 1'b1;
      endcase
   end

   assign set_ok = in_chan_ff ? (in_index_ff <= FbTop) : (in_index_ff <= HvTop);

   always_comb begin
      op_hv.sample_en = fire && is_sample && !in_chan_ff;
      op_hv.clear_en  = fire && is_clear;
      op_hv.set_en    = fire && is_set && set_ok && !in_chan_ff;
      op_hv.sample    = in_sample_ff;
      op_hv.set_index = in_index_ff;
      op_fb.sample_en = fire && is_sample && in_chan_ff;
      op_fb.clear_en  = fire && is_clear;
      op_fb.set_en    = fire && is_set && set_ok && in_chan_ff;
      op_fb.sample    = in_sample_ff;
      op_fb.set_index = in_index_ff;
   end

   always_comb begin
      cfg_hv.sat_high    = sat_high_ff;
      cfg_hv.sat_low     = sat_low_ff;
      cfg_hv.hold_reload = hold_reload_ff;
      cfg_hv.rms_mode    = rms_mode_ff;
      cfg_hv.vground     = vground_hv_ff;
      cfg_fb             = cfg_hv;
      cfg_fb.vground     = vground_fb_ff;
   end

   aac_chan u_chan_hv (
      .clock     (clock),
      .reset     (reset),
      .op        (op_hv),
      .cfg       (cfg_hv),
      .state_in  (hv_in),
      .state_ff  (hv_ff),
      .limit_hit (hit_hv)
   );

   aac_chan u_chan_fb (
      .clock     (clock),
      .reset     (reset),
      .op        (op_fb),
      .cfg       (cfg_fb),
      .state_in  (fb_in),
      .state_ff  (fb_ff),
      .limit_hit (hit_fb)
   );

   always_comb begin
      limit_flag_in = limit_flag_ff;
      if (op_hv.clear_en) begin
         limit_flag_in = 1'b0;
      end else if (hit_hv || hit_fb) begin
         limit_flag_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_flag_ff <= 1'b0;
      end else begin
         limit_flag_ff <= limit_flag_in;
      end
   end

   assign sel_in        = in_chan_ff ? fb_in : hv_in;
   assign rsp_status_in = is_bad || (is_set && !set_ok);
   assign rsp_data_in   = {sel_in.peak_low, sel_in.peak_high, sel_in.lvl_sum,
                           sel_in.sq_sum, limit_flag_in, sel_in.sat_count,
                           sel_in.range_idx};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   a_hv_range: assert property (@(posedge clock) disable iff (reset)
      hv_ff.range_idx <= HvTop)
      else $error("high-voltage range index above its top");

   a_fb_range: assert property (@(posedge clock) disable iff (reset)
      fb_ff.range_idx <= FbTop)
      else $error("feedback range index above its top");

   a_limit_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(limit_flag_ff) |-> $past(hit_hv || hit_fb))
      else $error("limit flag set without a saturation at the lowest index");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("buffered word lost during a result stall");
`endif

endmodule

// ----- test/tb_autoranging_adc_accumulator.sv -----
`timescale 1ns / 100ps

module tb_autoranging_adc_accumulator;
   import aac_pkg::*;

   localparam int HV_TOP = 2;
   localparam int FB_TOP = 4;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int RANDOM_PHASES = 8;
   localparam int WORDS_PER_PHASE = 160;
   localparam int SOAK_WORDS = 280;
   localparam int LONG_HOLD_CYCLES = 150;

   typedef struct packed {
      logic                   status;
      logic [RANGE_BITS-1:0]  range_index;
      logic [COUNT_BITS-1:0]  sat_count;
      logic                   limit;
      logic [SQ_BITS-1:0]     square_sum;
      logic [LVL_BITS-1:0]    level_sum;
      logic [SAMPLE_BITS-1:0] peak_high;
      logic [SAMPLE_BITS-1:0] peak_low;
   } window_report_type;

   typedef struct packed {
      logic [1:0]             cmd;
      logic                   ch;
      logic [SAMPLE_BITS-1:0] smp;
      logic [RANGE_BITS-1:0]  idx;
      logic                   typed;
      window_report_type      report;
   } script_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [REQ_USER_BITS-1:0] req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_wen;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   logic [SAMPLE_BITS-1:0] cfg_sat_high;
   logic [SAMPLE_BITS-1:0] cfg_sat_low;
   logic [HOLD_BITS-1:0]   cfg_hold;
   logic                   cfg_rms;
   logic [SAMPLE_BITS-1:0] cfg_vground [2];

   logic [RANGE_BITS-1:0]  range_now [2];
   logic [COUNT_BITS-1:0]  sat_events [2];
   logic [HOLD_BITS-1:0]   holdoff_left [2];
   logic [SQ_BITS-1:0]     square_acc [2];
   logic [LVL_BITS-1:0]    level_acc [2];
   logic [SAMPLE_BITS-1:0] top_seen [2];
   logic [SAMPLE_BITS-1:0] bottom_seen [2];
   logic                   limit_hit;

   window_report_type pending_reports [$];
   int mismatches = 0;
   int send_idle_pct = 36;
   int rsp_idle_pct = 86;
   bit rsp_hold_request = 1'b0;
   int rsp_hold_left = 0;

   script_row_type script [24] = '{
      '{CMD_SAMPLE,  1'b0, 10'd500,  3'd0, 1'b1, '{1'b0, 3'd0, 8'd0, 1'b0, 32'd0, 24'd0, 10'd500, 10'd500}},
      '{CMD_SET,     1'b0, 10'd0,    3'd2, 1'b1, '{1'b0, 3'd2, 8'd0, 1'b0, 32'd0, 24'd0, 10'd500, 10'd500}},
      '{CMD_SET,     1'b0, 10'd1023, 3'd3, 1'b1, '{1'b1, 3'd2, 8'd0, 1'b0, 32'd0, 24'd0, 10'd500, 10'd500}},
      '{CMD_SET,     1'b1, 10'd0,    3'd5, 1'b1, '{1'b1, 3'd0, 8'd0, 1'b0, 32'd0, 24'd0, 10'd0, 10'd1023}},
      '{CMD_SET,     1'b1, 10'd0,    3'd4, 1'b1, '{1'b0, 3'd4, 8'd0, 1'b0, 32'd0, 24'd0, 10'd0, 10'd1023}},
      '{CMD_SET,     1'b1, 10'd1023, 3'd7, 1'b1, '{1'b1, 3'd4, 8'd0, 1'b0, 32'd0, 24'd0, 10'd0, 10'd1023}},
      '{CMD_UNKNOWN, 1'b0, 10'd1023, 3'd7, 1'b1, '{1'b1, 3'd2, 8'd0, 1'b0, 32'd0, 24'd0, 10'd500, 10'd500}},
      '{CMD_SAMPLE,  1'b0, 10'd1023, 3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b0, 10'd0,    3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b0, 10'd1001, 3'd7, 1'b0, '0},
      '{CMD_SAMPLE,  1'b0, 10'd22,   3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b0, 10'd1023, 3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b0, 10'd0,    3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b0, 10'd1001, 3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b0, 10'd22,   3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b0, 10'd0,    3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b0, 10'd1023, 3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b0, 10'd1023, 3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b1, 10'd1000, 3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b1, 10'd23,   3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b1, 10'd1001, 3'd0, 1'b0, '0},
      '{CMD_CLEAR,   1'b1, 10'd1023, 3'd7, 1'b1, '{1'b0, 3'd3, 8'd0, 1'b0, 32'd0, 24'd0, 10'd0, 10'd1023}},
      '{CMD_SAMPLE,  1'b0, 10'd1000, 3'd0, 1'b0, '0},
      '{CMD_SAMPLE,  1'b1, 10'd0,    3'd0, 1'b0, '0}
   };

   autoranging_adc_accumulator #(
      .HV_TOP_INDEX(HV_TOP),
      .FB_TOP_INDEX(FB_TOP)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("autoranging_adc_accumulator verification failed");
      $finish;
   end

   function automatic void clear_window_state();
      for (int c = 0; c < 2; c++) begin
         sat_events[c] = '0;
         holdoff_left[c] = '0;
         square_acc[c] = '0;
         level_acc[c] = '0;
         top_seen[c] = '0;
         bottom_seen[c] = PEAK_LOW_RESET;
      end
      limit_hit = 1'b0;
   endfunction

   function automatic window_report_type advance_front_end(input logic [1:0] cmd, input logic ch,
                                                           input logic [SAMPLE_BITS-1:0] smp,
                                                           input logic [RANGE_BITS-1:0] idx);
      window_report_type r;
      int diff;
      longint square_total;
      longint level_total;
      int top_index;
      r.status = 1'b0;
      case (cmd)
         CMD_SAMPLE: begin
            if (smp > cfg_sat_high || smp < cfg_sat_low) begin
               if (holdoff_left[ch] == '0) begin
                  if (sat_events[ch] != COUNT_MAX) sat_events[ch]++;
                  if (range_now[ch] != '0) range_now[ch]--;
                  else limit_hit = 1'b1;
                  holdoff_left[ch] = cfg_hold;
               end else begin
                  holdoff_left[ch]--;
               end
            end else if (cfg_rms) begin
               diff = int'(smp) - int'(cfg_vground[ch]);
               square_total = longint'(square_acc[ch]) + longint'(diff * diff);
               level_total = longint'(level_acc[ch]) + longint'(smp);
               square_acc[ch] = (square_total > longint'(SQ_MAX)) ? SQ_MAX : square_total[31:0];
               level_acc[ch] = (level_total > longint'(LVL_MAX)) ? LVL_MAX : level_total[23:0];
            end else begin
               if (smp > top_seen[ch]) top_seen[ch] = smp;
               if (smp < bottom_seen[ch]) bottom_seen[ch] = smp;
            end
         end
         CMD_CLEAR: begin
            clear_window_state();
         end
         CMD_SET: begin
            top_index = ch ? FB_TOP : HV_TOP;
            if (int'(idx) <= top_index) range_now[ch] = idx;
            else r.status = 1'b1;
         end
         default: begin
            r.status = 1'b1;
         end
      endcase
      r.range_index = range_now[ch];
      r.sat_count = sat_events[ch];
      r.limit = limit_hit;
      r.square_sum = square_acc[ch];
      r.level_sum = level_acc[ch];
      r.peak_high = top_seen[ch];
      r.peak_low = bottom_seen[ch];
      return r;
   endfunction

   task automatic offer_word(input logic [1:0] cmd, input logic ch,
                             input logic [SAMPLE_BITS-1:0] smp, input logic [RANGE_BITS-1:0] idx,
                             input logic typed, input window_report_type typed_report);
      window_report_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, idx, smp};
      req_tuser <= {ch, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = advance_front_end(cmd, ch, smp, idx);
      pending_reports.push_back(typed ? typed_report : predicted);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_wen <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [SAMPLE_BITS-1:0] sat_high,
                            input logic [SAMPLE_BITS-1:0] sat_low,
                            input logic [HOLD_BITS-1:0] hold, input logic rms,
                            input logic [SAMPLE_BITS-1:0] vg_hv,
                            input logic [SAMPLE_BITS-1:0] vg_fb);
      write_reg(CSR_SAT_HIGH, sat_high);
      write_reg(CSR_SAT_LOW, sat_low);
      write_reg(CSR_HOLD, CSR_DATA_BITS'(hold));
      write_reg(CSR_RMS_MODE, CSR_DATA_BITS'(rms));
      write_reg(CSR_VGROUND_HV, vg_hv);
      write_reg(CSR_VGROUND_FB, vg_fb);
      csr_wen <= 1'b0;
      cfg_sat_high = sat_high;
      cfg_sat_low = sat_low;
      cfg_hold = hold;
      cfg_rms = rms;
      cfg_vground[0] = vg_hv;
      cfg_vground[1] = vg_fb;
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (rsp_hold_request) begin
         rsp_hold_left = LONG_HOLD_CYCLES;
         rsp_hold_request = 1'b0;
      end
      if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      window_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result word with nothing expected, data %h", $realtime, rsp_tdata);
         end else begin
            want = pending_reports.pop_front();
            check_field("status", want.status, rsp_tuser);
            check_field("range_index", want.range_index, rsp_tdata[2:0]);
            check_field("saturation_count", want.sat_count, rsp_tdata[10:3]);
            check_field("limit_exceeded", want.limit, rsp_tdata[11]);
            check_field("square_sum", want.square_sum, rsp_tdata[43:12]);
            check_field("level_sum", want.level_sum, rsp_tdata[67:44]);
            check_field("peak_high", want.peak_high, rsp_tdata[77:68]);
            check_field("peak_low", want.peak_low, rsp_tdata[87:78]);
         end
      end
   end

   initial begin : stimulus
      int pick;
      logic [1:0] cmd;
      logic ch;
      logic [SAMPLE_BITS-1:0] smp;
      logic [RANGE_BITS-1:0] idx;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_wen = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      cfg_sat_high = SAT_HIGH_RESET;
      cfg_sat_low = SAT_LOW_RESET;
      cfg_hold = HOLD_RESET;
      cfg_rms = 1'b0;
      cfg_vground[0] = VGROUND_RESET;
      cfg_vground[1] = VGROUND_RESET;
      range_now[0] = '0;
      range_now[1] = '0;
      clear_window_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         offer_word(script[i].cmd, script[i].ch, script[i].smp, script[i].idx,
                    script[i].typed, script[i].report);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         if (phase < 3) begin
            send_idle_pct = 36;
            rsp_idle_pct = 86;
         end else if (phase < 6) begin
            send_idle_pct = 86;
            rsp_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         case (phase)
            0: configure(10'd1023, 10'd0, 8'd0, 1'b1, 10'd0, 10'd1023);
            1: configure(10'd0, 10'd1023, 8'd255, 1'b0, 10'd1023, 10'd0);
            5: configure(10'($urandom_range(500, 300)), 10'($urandom_range(700, 501)),
                         8'($urandom_range(3)), 1'($urandom_range(1)),
                         10'($urandom_range(1023)), 10'($urandom_range(1023)));
            default: configure(10'($urandom_range(1023, 600)), 10'($urandom_range(400)),
                               8'($urandom_range(6)), 1'($urandom_range(1)),
                               10'($urandom_range(1023)), 10'($urandom_range(1023)));
         endcase
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (phase == 6 && n == 50) rsp_hold_request = 1'b1;
            if (phase == 4 && n == 120) begin
               req_tvalid <= 1'b0;
               while (pending_reports.size() != 0) @(posedge clock);
            end
            pick = $urandom_range(99);
            if (pick < 75) cmd = CMD_SAMPLE;
            else if (pick < 78) cmd = CMD_CLEAR;
            else if (pick < 96) cmd = CMD_SET;
            else cmd = CMD_UNKNOWN;
            ch = 1'($urandom_range(1));
            idx = 3'($urandom_range(7));
            pick = $urandom_range(99);
            if (pick < 12) smp = 10'($urandom_range(1023));
            else if (pick < 30) smp = cfg_sat_high + 10'($urandom_range(2)) - 10'd1;
            else if (pick < 45) smp = cfg_sat_low + 10'($urandom_range(2)) - 10'd1;
            else if (cfg_sat_low <= cfg_sat_high)
               smp = 10'($urandom_range(cfg_sat_high, cfg_sat_low));
            else smp = 10'($urandom_range(1023));
            offer_word(cmd, ch, smp, idx, 1'b0, '0);
         end
      end

      drain_results();
      configure(10'd1023, 10'd1, 8'd0, 1'b1, 10'd0, 10'd512);
      offer_word(CMD_CLEAR, 1'b0, 10'd0, 3'd0, 1'b0, '0);
      for (int n = 0; n < SOAK_WORDS; n++) begin
         offer_word(CMD_SAMPLE, 1'b0, 10'd1023, 3'($urandom_range(7)), 1'b0, '0);
         offer_word(CMD_SAMPLE, 1'b1, 10'd0, 3'($urandom_range(7)), 1'b0, '0);
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("autoranging_adc_accumulator verification clean");
      end else begin
         $display("autoranging_adc_accumulator verification failed");
      end
      $finish;
   end

endmodule
